### hdl/zctd_pkg.sv
// package for the z-character text decoder
// result kinds, z-character codes and the default alphabet rom
// no dependencies
package zctd_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ZCHAR_W  = 5;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned ROW_W    = 2;

  localparam int unsigned ALPHA_DEPTH = 78;
  localparam int unsigned ROW_LEN     = 26;

  localparam logic [ZCHAR_W-1:0] ZC_SPACE      = 5'd0;
  localparam logic [ZCHAR_W-1:0] ZC_ABBREV_MAX = 5'd3;
  localparam logic [ZCHAR_W-1:0] ZC_SHIFT_UP   = 5'd4;
  localparam logic [ZCHAR_W-1:0] ZC_SHIFT_PUNC = 5'd5;
  localparam logic [ZCHAR_W-1:0] ZC_ESCAPE     = 5'd6;

  localparam logic [ROW_W-1:0] ROW_LOWER = 2'd0;
  localparam logic [ROW_W-1:0] ROW_UPPER = 2'd1;
  localparam logic [ROW_W-1:0] ROW_PUNC  = 2'd2;

  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'd32;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_ABBREV = 2'd2
  } result_kind_t;

  localparam logic [8*ALPHA_DEPTH-1:0] ALPHABET = {
    "abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "\033\n0123456789.,!?_#'\"/\\-:()"
  };

  // first character of the string sits in the top byte
  function automatic logic [CODE_W-1:0] alpha_char(input logic [INDEX_W-1:0] idx);
    logic [INDEX_W-1:0] rev;
    rev = INDEX_W'(ALPHA_DEPTH - 1) - idx;
    if (idx < INDEX_W'(ALPHA_DEPTH)) begin
      return ALPHABET[{rev, 3'b000} +: CODE_W];
    end
    return '0;
  endfunction

endpackage

### hdl/zctd_ifs.sv
// valid/ready channel interfaces of the z-character text decoder
// depends on zctd_pkg
interface zctd_text_if;
  logic                       valid;
  logic                       ready;
  logic [zctd_pkg::WORD_W-1:0] text_word;

  modport source (output valid, output text_word, input ready);
  modport sink   (input valid, input text_word, output ready);
endinterface

interface zctd_result_if;
  logic                          valid;
  logic                          ready;
  zctd_pkg::result_kind_t        result_kind;
  logic [zctd_pkg::CODE_W-1:0]   char_code;
  logic [zctd_pkg::INDEX_W-1:0]  abbrev_index;
  logic                          last_of_word;
  logic                          end_of_text;

  modport source (output valid, output result_kind, output char_code, output abbrev_index,
                  output last_of_word, output end_of_text, input ready);
  modport sink   (input valid, input result_kind, input char_code, input abbrev_index,
                  input last_of_word, input end_of_text, output ready);
endinterface

### hdl/zchar_text_decoder.sv
// z-character text decoder top level: word buffer, one-per-cycle decode when not stalled, result register
// depends on zctd_pkg and zctd_ifs
//
//   channel  dir  payload
//   text     in   text_word
//   result   out  result_kind, char_code, abbrev_index, last_of_word, end_of_text
//
// each word gives three results, one per cycle while the result register is not stalled;
// the three z-characters share one decode path between word buffer and result register
// the next word is taken in the cycle its predecessor's third z-character is decoded
// a stalled result register holds decode; rst (synchronous) clears all decode state
module zchar_text_decoder (
  input  logic                 clk,
  input  logic                 rst,
  zctd_text_if.sink            text,
  zctd_result_if.source        result
);
  import zctd_pkg::*;

  typedef enum logic [1:0] {
    EXT_IDLE = 2'd0,
    EXT_HIGH = 2'd1,
    EXT_LOW  = 2'd2
  } ext_stage_t;

  logic [WORD_W-2:0]  word;
  logic               word_end;
  logic               word_valid;
  logic [1:0]         zsel;

  logic [ROW_W-1:0]   shift_row;
  logic [ROW_W-1:0]   abbrev_bank;
  ext_stage_t         ext_stage;
  logic [ZCHAR_W-1:0] ext_high;

  logic               out_valid;
  result_kind_t       out_kind;
  logic [CODE_W-1:0]  out_code;
  logic [INDEX_W-1:0] out_index;
  logic               out_last;
  logic               out_end;

  logic               advance;
  logic               last_z;
  logic               accept;
  logic [ZCHAR_W-1:0] zc;
  logic [ROW_W-1:0]   row_eff;
  logic [INDEX_W-1:0] rom_idx;

  result_kind_t       kind_next;
  logic [CODE_W-1:0]  code_next;
  logic [INDEX_W-1:0] index_next;
  logic [ROW_W-1:0]   shift_row_next;
  logic [ROW_W-1:0]   abbrev_bank_next;
  ext_stage_t         ext_stage_next;
  logic [ZCHAR_W-1:0] ext_high_next;

  assign advance    = word_valid && (!out_valid || result.ready);
  assign last_z     = (zsel == 2'd2);
  assign text.ready = !word_valid || (advance && last_z);
  assign accept     = text.valid && text.ready;

  always_comb begin
    case (zsel)
      2'd0:    zc = word[14:10];
      2'd1:    zc = word[9:5];
      default: zc = word[4:0];
    endcase
  end

  assign row_eff = (shift_row > ROW_PUNC) ? ROW_LOWER : shift_row;
  assign rom_idx = INDEX_W'(row_eff) * INDEX_W'(ROW_LEN) + INDEX_W'(zc)
                   - INDEX_W'(ZC_ESCAPE);

  always_comb begin
    kind_next        = KIND_NONE;
    code_next        = '0;
    index_next       = '0;
    shift_row_next   = shift_row;
    abbrev_bank_next = abbrev_bank;
    ext_stage_next   = ext_stage;
    ext_high_next    = ext_high;
    if (abbrev_bank != '0) begin
      kind_next        = KIND_ABBREV;
      index_next       = {abbrev_bank - 2'd1, zc};
      abbrev_bank_next = '0;
      shift_row_next   = ROW_LOWER;
      ext_stage_next   = EXT_IDLE;
    end else if (ext_stage == EXT_HIGH) begin
      ext_high_next  = zc;
      ext_stage_next = EXT_LOW;
    end else if (ext_stage != EXT_IDLE) begin
      kind_next      = KIND_CHAR;
      code_next      = {ext_high[2:0], zc};
      ext_stage_next = EXT_IDLE;
    end else if (zc == ZC_SPACE) begin
      kind_next = KIND_CHAR;
      code_next = CHAR_SPACE;
    end else if (zc <= ZC_ABBREV_MAX) begin
      abbrev_bank_next = zc[ROW_W-1:0];
    end else if (zc == ZC_SHIFT_UP) begin
      shift_row_next = ROW_UPPER;
    end else if (zc == ZC_SHIFT_PUNC) begin
      shift_row_next = ROW_PUNC;
    end else if (shift_row == ROW_PUNC && zc == ZC_ESCAPE) begin
      shift_row_next = ROW_LOWER;
      ext_stage_next = EXT_HIGH;
    end else begin
      kind_next      = KIND_CHAR;
      code_next      = alpha_char(rom_idx);
      shift_row_next = ROW_LOWER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid  <= 1'b0;
      zsel        <= 2'd0;
      shift_row   <= ROW_LOWER;
      abbrev_bank <= '0;
      ext_stage   <= EXT_IDLE;
      ext_high    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        out_kind  <= kind_next;
        out_code  <= code_next;
        out_index <= index_next;
        out_last  <= last_z;
        out_end   <= last_z && word_end;
        if (last_z && word_end) begin
          shift_row   <= ROW_LOWER;
          abbrev_bank <= '0;
          ext_stage   <= EXT_IDLE;
          ext_high    <= '0;
        end else begin
          shift_row   <= shift_row_next;
          abbrev_bank <= abbrev_bank_next;
          ext_stage   <= ext_stage_next;
          ext_high    <= ext_high_next;
        end
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        word       <= text.text_word[WORD_W-2:0];
        word_end   <= text.text_word[WORD_W-1];
        word_valid <= 1'b1;
        zsel       <= 2'd0;
      end else if (advance) begin
        if (last_z) begin
          word_valid <= 1'b0;
          zsel       <= 2'd0;
        end else begin
          zsel <= zsel + 2'd1;
        end
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.result_kind  = out_kind;
  assign result.char_code    = out_code;
  assign result.abbrev_index = out_index;
  assign result.last_of_word = out_last;
  assign result.end_of_text  = out_end;

`ifndef NO_ASSERTIONS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |-> out_last)
    else $error("end_of_text without last_of_word");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && last_z && word_end |=>
      shift_row == ROW_LOWER && abbrev_bank == '0 && ext_stage == EXT_IDLE)
    else $error("decode state not cleared after end of text");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> word_valid && zsel == 2'd0)
    else $error("accepted word not loaded at first z-character");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    shift_row != 2'd3)
    else $error("alphabet row out of range");
`endif

endmodule
